// ===== src/jps_pkg.sv =====
// ----------------------------------------------------------------------------
// jps_pkg
// Shared types, codes and constants of the Jacobi pressure solver.
// ----------------------------------------------------------------------------
package jps_pkg;

   localparam int DEF_MAX_WIDTH     = 128;
   localparam int DEF_MAX_HEIGHT    = 128;
   localparam int DEF_PRESSURE_BITS = 24;

   localparam int COORD_BITS = 7;
   localparam int VEL_BITS   = 16;
   localparam int DIV_BITS   = 18;
   localparam int DIM_BITS   = 8;
   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [DIM_BITS-1:0] RST_GRID_WIDTH  = 8'd128;
   localparam logic [DIM_BITS-1:0] RST_GRID_HEIGHT = 8'd128;
   localparam logic [DIM_BITS-1:0] RST_SWEEP_COUNT = 8'd5;

   typedef enum logic [1:0] {
      OP_LOAD  = 2'd0,
      OP_SOLVE = 2'd1,
      OP_READ  = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      REG_GRID_WIDTH  = 2'd0,
      REG_GRID_HEIGHT = 2'd1,
      REG_SWEEP_COUNT = 2'd2,
      REG_UNUSED      = 2'd3
   } reg_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV_RD1,
      ST_DIV_RD2,
      ST_DIV_WR,
      ST_SW_PRIME,
      ST_SW_PRIMEW,
      ST_SW_RD1,
      ST_SW_RD2,
      ST_SW_CALC,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic                         load;
      logic                         run;
      logic                         read;
      logic [COORD_BITS-1:0]        x;
      logic [COORD_BITS-1:0]        y;
      logic signed [VEL_BITS-1:0]   vx;
      logic signed [VEL_BITS-1:0]   vy;
   } eng_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
      logic saturated;
   } eng_stat_type;

endpackage

// ===== src/jps_cell.sv =====
// ----------------------------------------------------------------------------
// jps_cell
// One cell of the horizontal pressure window: holds a value and passes it on.
// ----------------------------------------------------------------------------
module jps_cell #(
   parameter int WIDTH = jps_pkg::DEF_PRESSURE_BITS
) (
   input  logic             clock,
   input  logic             shift,
   input  logic             zero,
   input  logic [WIDTH-1:0] d,
   output logic [WIDTH-1:0] q
);

   logic [WIDTH-1:0] value_ff;
   logic [WIDTH-1:0] value_in;

   // The first sweep reads a source bank that is all zero by definition.
   assign value_in = zero ? '0 : d;

   always_ff @(posedge clock) begin
      if (shift) begin
         value_ff <= value_in;
      end
   end

   assign q = value_ff;

endmodule

// ===== src/jps_engine.sv =====
// ----------------------------------------------------------------------------
// jps_engine
// Grid stores, divergence pass and Jacobi sweep sequencer.
// ----------------------------------------------------------------------------
module jps_engine #(
   parameter int MAX_WIDTH     = jps_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT    = jps_pkg::DEF_MAX_HEIGHT,
   parameter int PRESSURE_BITS = jps_pkg::DEF_PRESSURE_BITS
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  jps_pkg::eng_cmd_type                  cmd,
   input  logic [$clog2(MAX_WIDTH):0]            dim_w,
   input  logic [$clog2(MAX_HEIGHT):0]           dim_h,
   input  logic [jps_pkg::DIM_BITS-1:0]          sweeps,
   output jps_pkg::eng_stat_type                 stat,
   output logic [PRESSURE_BITS-1:0]              rd_pressure
);
   import jps_pkg::*;

   localparam int XW    = $clog2(MAX_WIDTH);
   localparam int YW    = $clog2(MAX_HEIGHT);
   localparam int AW    = XW + YW;
   localparam int CELLS = 1 << AW;
   localparam int P     = PRESSURE_BITS;
   localparam int SW    = P + 3;

   logic [2*VEL_BITS-1:0]  vel_mem  [CELLS];
   logic [DIV_BITS-1:0]    div_mem  [CELLS];
   logic [P-1:0]           pres_mem [2*CELLS];

   state_type state_ff, state_in;

   logic [XW-1:0] x_ff;
   logic [YW-1:0] y_ff;
   logic [7:0]    k_ff;
   logic          cur_ff, first_ff, sat_ff, bank_ff, has_ff, nodata_ff;
   logic [XW:0]   ws_ff;
   logic [YW:0]   hs_ff;
   logic signed [VEL_BITS:0] dx_ff;

   logic [2*VEL_BITS-1:0] va_ff, vb_ff;
   logic [DIV_BITS-1:0]   dr_ff;
   logic [P-1:0]          pa_ff, pb_ff;

   logic [XW:0]   x_nxt;
   logic [YW:0]   y_nxt;
   logic          x_last, y_last;
   logic [XW-1:0] xl, xr;
   logic [YW-1:0] yb, yt;
   logic [AW-1:0] cell_addr, cmd_addr;

   logic [AW-1:0] va_addr, vb_addr;
   logic [AW:0]   pa_addr, pb_addr;
   logic          div_we, pres_we, shift;

   logic signed [VEL_BITS:0]   dy;
   logic signed [DIV_BITS-1:0] div_val;
   logic [P-1:0]  w_new, w_mid, w_old;
   logic [P-1:0]  p_l, p_r, p_b, p_t;
   logic signed [SW-1:0] sum, quarter;
   logic          ovf;
   logic [P-1:0]  p_out;

   assign x_nxt     = {1'b0, x_ff} + 1'b1;
   assign y_nxt     = {1'b0, y_ff} + 1'b1;
   assign x_last    = (x_nxt == dim_w);
   assign y_last    = (y_nxt == dim_h);
   assign xl        = (x_ff == '0) ? '0 : x_ff - 1'b1;
   assign xr        = x_last ? x_ff : x_nxt[XW-1:0];
   assign yb        = (y_ff == '0) ? '0 : y_ff - 1'b1;
   assign yt        = y_last ? y_ff : y_nxt[YW-1:0];
   assign cell_addr = {y_ff, x_ff};
   assign cmd_addr  = {YW'(cmd.y), XW'(cmd.x)};

   // Memories
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         vel_mem[cmd_addr] <= {cmd.vx, cmd.vy};
      end
      va_ff <= vel_mem[va_addr];
      vb_ff <= vel_mem[vb_addr];
   end

   always_ff @(posedge clock) begin
      if (div_we) begin
         div_mem[cell_addr] <= div_val;
      end
      dr_ff <= div_mem[cell_addr];
   end

   always_ff @(posedge clock) begin
      if (pres_we) begin
         pres_mem[{~cur_ff, cell_addr}] <= p_out;
      end
      pa_ff <= pres_mem[pa_addr];
      pb_ff <= pres_mem[pb_addr];
   end

   // Horizontal window: newest holds the right neighbor, oldest the left one.
   jps_cell #(.WIDTH(P)) u_cell_new (
      .clock(clock), .shift(shift), .zero(first_ff), .d(pa_ff), .q(w_new)
   );
   jps_cell #(.WIDTH(P)) u_cell_mid (
      .clock(clock), .shift(shift), .zero(first_ff), .d(w_new), .q(w_mid)
   );
   jps_cell #(.WIDTH(P)) u_cell_old (
      .clock(clock), .shift(shift), .zero(first_ff), .d(w_mid), .q(w_old)
   );

   // Divergence arithmetic
   assign dy      = {vb_ff[VEL_BITS-1], vb_ff[VEL_BITS-1:0]}
                  - {va_ff[VEL_BITS-1], va_ff[VEL_BITS-1:0]};
   assign div_val = {dx_ff[VEL_BITS], dx_ff} + {dy[VEL_BITS], dy};

   // Jacobi update with clamped neighbors
   assign p_l = (x_ff == '0) ? w_mid : w_old;
   assign p_r = x_last ? w_mid : w_new;
   assign p_b = first_ff ? '0 : pa_ff;
   assign p_t = first_ff ? '0 : pb_ff;

   always_comb begin
      sum = {{3{p_l[P-1]}}, p_l} + {{3{p_r[P-1]}}, p_r}
          + {{3{p_b[P-1]}}, p_b} + {{3{p_t[P-1]}}, p_t}
          - {{(SW-DIV_BITS){dr_ff[DIV_BITS-1]}}, dr_ff};
      quarter = sum >>> 2;
      ovf = !((quarter[SW-1:P-1] == '0) || (quarter[SW-1:P-1] == '1));
      if (!ovf) begin
         p_out = quarter[P-1:0];
      end else if (quarter[SW-1]) begin
         p_out = {1'b1, {(P-1){1'b0}}};
      end else begin
         p_out = {1'b0, {(P-1){1'b1}}};
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:      if (cmd.run) state_in = ST_DIV_RD1;
         ST_DIV_RD1:   state_in = ST_DIV_RD2;
         ST_DIV_RD2:   state_in = ST_DIV_WR;
         ST_DIV_WR: begin
            if (!x_last || !y_last) begin
               state_in = ST_DIV_RD1;
            end else if (sweeps == '0) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_SW_PRIME;
            end
         end
         ST_SW_PRIME:  state_in = ST_SW_PRIMEW;
         ST_SW_PRIMEW: state_in = ST_SW_RD1;
         ST_SW_RD1:    state_in = ST_SW_RD2;
         ST_SW_RD2:    state_in = ST_SW_CALC;
         ST_SW_CALC: begin
            if (!x_last) begin
               state_in = ST_SW_RD1;
            end else if (!y_last) begin
               state_in = ST_SW_PRIME;
            end else if (8'(k_ff + 8'd1) == sweeps) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_SW_PRIME;
            end
         end
         ST_DONE:      state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   // Outputs of the sequencer
   always_comb begin
      va_addr = cell_addr;
      vb_addr = cell_addr;
      pa_addr = {cur_ff, cell_addr};
      pb_addr = {cur_ff, cell_addr};
      div_we  = 1'b0;
      pres_we = 1'b0;
      shift   = 1'b0;
      unique case (state_ff)
         ST_IDLE:      pa_addr = {bank_ff, cmd_addr};
         ST_DIV_RD1: begin
            va_addr = {y_ff, xl};
            vb_addr = {y_ff, xr};
         end
         ST_DIV_RD2: begin
            va_addr = {yb, x_ff};
            vb_addr = {yt, x_ff};
         end
         ST_DIV_WR:    div_we = 1'b1;
         ST_SW_PRIME:  pa_addr = {cur_ff, y_ff, {XW{1'b0}}};
         ST_SW_PRIMEW: shift = 1'b1;
         ST_SW_RD1:    pa_addr = {cur_ff, y_ff, x_nxt[XW-1:0]};
         ST_SW_RD2: begin
            shift   = 1'b1;
            pa_addr = {cur_ff, yb, x_ff};
            pb_addr = {cur_ff, yt, x_ff};
         end
         ST_SW_CALC:   pres_we = 1'b1;
         ST_DONE:      shift = 1'b0;
         default:      shift = 1'b0;
      endcase
   end

   // Sequencer registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         x_ff     <= '0;
         y_ff     <= '0;
         k_ff     <= '0;
         cur_ff   <= 1'b0;
         first_ff <= 1'b0;
         sat_ff   <= 1'b0;
         bank_ff  <= 1'b0;
         has_ff   <= 1'b0;
         ws_ff    <= '0;
         hs_ff    <= '0;
      end else begin
         state_ff <= state_in;
         case (state_ff)
            ST_IDLE: begin
               if (cmd.run) begin
                  x_ff   <= '0;
                  y_ff   <= '0;
                  sat_ff <= 1'b0;
               end
            end
            ST_DIV_WR: begin
               if (x_last) begin
                  x_ff <= '0;
                  if (y_last) begin
                     y_ff     <= '0;
                     k_ff     <= '0;
                     cur_ff   <= 1'b0;
                     first_ff <= 1'b1;
                  end else begin
                     y_ff <= y_nxt[YW-1:0];
                  end
               end else begin
                  x_ff <= x_nxt[XW-1:0];
               end
            end
            ST_SW_CALC: begin
               sat_ff <= sat_ff | ovf;
               if (x_last) begin
                  x_ff <= '0;
                  if (y_last) begin
                     y_ff     <= '0;
                     k_ff     <= 8'(k_ff + 8'd1);
                     cur_ff   <= ~cur_ff;
                     first_ff <= 1'b0;
                  end else begin
                     y_ff <= y_nxt[YW-1:0];
                  end
               end else begin
                  x_ff <= x_nxt[XW-1:0];
               end
            end
            ST_DONE: begin
               bank_ff <= cur_ff;
               has_ff  <= (sweeps != '0);
               ws_ff   <= dim_w;
               hs_ff   <= dim_h;
            end
            default: begin
            end
         endcase
      end
   end

   // Divergence partial and read bookkeeping
   always_ff @(posedge clock) begin
      if (state_ff == ST_DIV_RD2) begin
         dx_ff <= {vb_ff[2*VEL_BITS-1], vb_ff[2*VEL_BITS-1:VEL_BITS]}
                - {va_ff[2*VEL_BITS-1], va_ff[2*VEL_BITS-1:VEL_BITS]};
      end
      if (cmd.read) begin
         // Cells beyond the last solved grid, or any cell before a solve
         // with sweeps, hold pressure zero.
         nodata_ff <= !has_ff || (int'(cmd.x) >= int'(ws_ff))
                   || (int'(cmd.y) >= int'(hs_ff));
      end
   end

   assign rd_pressure    = nodata_ff ? '0 : pa_ff;
   assign stat.busy      = (state_ff != ST_IDLE);
   assign stat.done      = (state_ff == ST_DONE);
   assign stat.saturated = sat_ff;

endmodule

// ===== src/jacobi_pressure_solver.sv =====
// ----------------------------------------------------------------------------
// jacobi_pressure_solver
// Jacobi pressure solver for a 2D velocity grid, with register port.
// ----------------------------------------------------------------------------
// Commands enter on start with req_op and the req_ fields and are taken when
// busy is low. Each taken command other than the unused code gives exactly
// one result on the rsp_ ports, flagged by rsp_valid for one cycle; the
// receiver cannot stall it.
// A velocity load or a pressure read is taken every cycle while the block is
// idle, and its result appears in the cycle after the transfer.
// A solve raises busy. It first walks the grid once for divergence, reading
// the left and right, then the lower and upper velocities of each cell and
// writing its divergence. Each sweep then primes the pressure window at the
// start of every row and reads, for each cell, its right neighbor and then
// its lower and upper neighbors from a pressure bank with two read ports.
// Reset restores the register defaults, returns to idle and makes every
// pressure read give zero until a solve with sweeps has finished; no memory
// clearing pass is needed.
// ----------------------------------------------------------------------------
module jacobi_pressure_solver #(
   parameter int MAX_WIDTH     = jps_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT    = jps_pkg::DEF_MAX_HEIGHT,
   parameter int PRESSURE_BITS = jps_pkg::DEF_PRESSURE_BITS
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic [1:0]                            req_op,
   input  logic [jps_pkg::COORD_BITS-1:0]        req_cell_x,
   input  logic [jps_pkg::COORD_BITS-1:0]        req_cell_y,
   input  logic signed [jps_pkg::VEL_BITS-1:0]   req_vel_x,
   input  logic signed [jps_pkg::VEL_BITS-1:0]   req_vel_y,
   output logic                                  rsp_valid,
   output logic [1:0]                            rsp_kind,
   output logic signed [PRESSURE_BITS-1:0]       rsp_pressure,
   output logic                                  rsp_saturated,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [jps_pkg::CSR_ADDR_BITS-1:0]     paddr,
   input  logic [jps_pkg::CSR_DATA_BITS-1:0]     pwdata,
   output logic [jps_pkg::CSR_DATA_BITS-1:0]     prdata,
   output logic                                  pready
);
   import jps_pkg::*;

   localparam int XW = $clog2(MAX_WIDTH);
   localparam int YW = $clog2(MAX_HEIGHT);

   logic [DIM_BITS-1:0] width_ff, height_ff, sweeps_ff;
   logic [XW:0]         dim_w;
   logic [YW:0]         dim_h;
   reg_index_type       reg_idx;
   logic                csr_write;

   op_type       op;
   logic         accept, on_grid;
   eng_cmd_type  cmd;
   eng_stat_type stat;
   logic [PRESSURE_BITS-1:0] rd_pressure;

   logic   rsp_valid_ff, on_grid_ff;
   op_type kind_ff;

   // Register port
   assign pready    = 1'b1;
   assign reg_idx   = reg_index_type'(paddr[CSR_ADDR_BITS-1:2]);
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= RST_GRID_WIDTH;
         height_ff <= RST_GRID_HEIGHT;
         sweeps_ff <= RST_SWEEP_COUNT;
      end else if (csr_write) begin
         unique case (reg_idx)
            REG_GRID_WIDTH:  width_ff  <= pwdata[DIM_BITS-1:0];
            REG_GRID_HEIGHT: height_ff <= pwdata[DIM_BITS-1:0];
            REG_SWEEP_COUNT: sweeps_ff <= pwdata[DIM_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      prdata = '0;
      unique case (reg_idx)
         REG_GRID_WIDTH:  prdata = {{(CSR_DATA_BITS-DIM_BITS){1'b0}}, width_ff};
         REG_GRID_HEIGHT: prdata = {{(CSR_DATA_BITS-DIM_BITS){1'b0}}, height_ff};
         REG_SWEEP_COUNT: prdata = {{(CSR_DATA_BITS-DIM_BITS){1'b0}}, sweeps_ff};
         default:         prdata = '0;
      endcase
   end

   // Out-of-range sizes act as the nearest legal size.
   always_comb begin
      if (width_ff == '0) begin
         dim_w = (XW+1)'(1);
      end else if (int'(width_ff) > MAX_WIDTH) begin
         dim_w = (XW+1)'(MAX_WIDTH);
      end else begin
         dim_w = (XW+1)'(width_ff);
      end
      if (height_ff == '0) begin
         dim_h = (YW+1)'(1);
      end else if (int'(height_ff) > MAX_HEIGHT) begin
         dim_h = (YW+1)'(MAX_HEIGHT);
      end else begin
         dim_h = (YW+1)'(height_ff);
      end
   end

   // Command decode
   assign op      = op_type'(req_op);
   assign accept  = start && !busy;
   assign on_grid = (int'(req_cell_x) < int'(dim_w)) && (int'(req_cell_y) < int'(dim_h));

   assign cmd.load  = accept && (op == OP_LOAD) && on_grid;
   assign cmd.run   = accept && (op == OP_SOLVE);
   assign cmd.read  = accept && (op == OP_READ);
   assign cmd.x     = req_cell_x;
   assign cmd.y     = req_cell_y;
   assign cmd.vx    = req_vel_x;
   assign cmd.vy    = req_vel_y;

   jps_engine #(
      .MAX_WIDTH    (MAX_WIDTH),
      .MAX_HEIGHT   (MAX_HEIGHT),
      .PRESSURE_BITS(PRESSURE_BITS)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .dim_w      (dim_w),
      .dim_h      (dim_h),
      .sweeps     (sweeps_ff),
      .stat       (stat),
      .rd_pressure(rd_pressure)
   );

   assign busy = stat.busy;

   // Result stage. A solve answers only once its last sweep, if any, ends.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= (accept && ((op == OP_LOAD) || (op == OP_READ))) || stat.done;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff    <= stat.done ? OP_SOLVE : op;
      on_grid_ff <= on_grid;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_kind      = kind_ff;
   assign rsp_pressure  = ((kind_ff == OP_READ) && on_grid_ff) ? rd_pressure : '0;
   assign rsp_saturated = stat.saturated;

endmodule

// ===== src/jps_checker.sv =====
// ----------------------------------------------------------------------------
// jps_checker
// Port-level checks of the Jacobi pressure solver, bound to the top level.
// ----------------------------------------------------------------------------
module jps_checker #(
   parameter int PRESSURE_BITS = jps_pkg::DEF_PRESSURE_BITS
) (
   input logic                               clock,
   input logic                               reset,
   input logic                               start,
   input logic                               busy,
   input logic [1:0]                         req_op,
   input logic                               rsp_valid,
   input logic [1:0]                         rsp_kind,
   input logic signed [PRESSURE_BITS-1:0]    rsp_pressure
);
   import jps_pkg::*;

   // A load or read transfer is answered in the very next cycle.
   a_load_ack: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_op == OP_LOAD) |=> rsp_valid && (rsp_kind == OP_LOAD))
      else $error("load transfer not acknowledged in the next cycle");

   a_read_data: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_op == OP_READ) |=> rsp_valid && (rsp_kind == OP_READ))
      else $error("read transfer not answered in the next cycle");

   // A solve keeps the block busy while it walks the grid.
   a_solve_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_op == OP_SOLVE) |=> busy && !rsp_valid)
      else $error("solve transfer did not raise busy");

   // Only reads carry pressure.
   a_zero_pressure: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind != OP_READ) |-> (rsp_pressure == '0))
      else $error("non-read result carries pressure");

   a_no_unused: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_kind != OP_NONE))
      else $error("result with unused kind");

endmodule

bind jacobi_pressure_solver jps_checker #(
   .PRESSURE_BITS(PRESSURE_BITS)
) u_jps_checker (
   .clock       (clock),
   .reset       (reset),
   .start       (start),
   .busy        (busy),
   .req_op      (req_op),
   .rsp_valid   (rsp_valid),
   .rsp_kind    (rsp_kind),
   .rsp_pressure(rsp_pressure)
);
